@@ hdl/ilid_pkg.sv @@
// Shared constants, types and codes for the indexed list insert/delete block.
package ilid_pkg;

   localparam int CAPACITY = 64;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 7;
   localparam int COUNT_W  = 7;
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 2;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef logic signed [VALUE_W-1:0] value_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_READ       = 3'd0,
      CMD_INS_HEAD   = 3'd1,
      CMD_INS_TAIL   = 3'd2,
      CMD_INS_BEFORE = 3'd3,
      CMD_DELETE     = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Broadcast to every cell: what happens this cycle and where.
   typedef struct packed {
      logic             ins;
      logic             del;
      logic [IDX_W-1:0] pos;
   } cell_op_type;

endpackage

@@ hdl/ilid_cell.sv @@
// One storage cell of the list: holds one element and shifts with its neighbors.
module ilid_cell
   import ilid_pkg::*;
(
   input  logic             clock,
   input  cell_op_type      op,
   input  logic [IDX_W-1:0] index,
   input  value_type        left_value,
   input  value_type        right_value,
   input  value_type        new_value,
   output value_type        value
);

   value_type value_ff;
   value_type value_in;

   always_comb begin
      value_in = value_ff;
      if (op.ins) begin
         if (index == op.pos) begin
            value_in = new_value;
         end else if (index > op.pos) begin
            value_in = left_value;
         end
      end else if (op.del) begin
         if (index >= op.pos) begin
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

@@ hdl/indexed_list_insert_delete.sv @@
// Top level of the indexed list: a row of CAPACITY cells plus command decode.
// A request's response is registered and shows in the cycle after accept.
// Throughput: one request per cycle; inserts and deletes shift the cells from their position up at once.
// The response register decouples the sides: a new request is taken whenever the
// held response is absent or taken in the same cycle.
// Reset (synchronous, active high) empties the list and drops any held response.
module indexed_list_insert_delete
   import ilid_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [POS_W-1:0]    req_position,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [VALUE_W-1:0] rsp_read_value,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_count
);

   // Element count.
   logic [CNT_W-1:0] occ_ff;
   logic [CNT_W-1:0] occ_in;

   // Response register.
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   value_type        rsp_read_value_ff;
   status_type       rsp_status_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   // Decode results.
   value_type        rd_value;
   status_type       status;
   logic             ins_ok;
   logic             del_ok;
   logic [CMP_W-1:0] ins_pos;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] occ_ext;
   logic [CMP_W-1:0] occ_next_ext;
   logic             accept;
   cmd_type          cmd;
   cell_op_type      op;

   value_type        cell_value [CAPACITY];

   // Hold the request while a response waits and the consumer stalls.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign cmd     = cmd_type'(req_command);
   assign pos_ext = CMP_W'(req_position);
   assign occ_ext = CMP_W'(occ_ff);

   // Decode the command: pick the insert point, check range and fullness,
   // and select the element for a read.
   always_comb begin
      logic ins_req;
      ins_req  = 1'b0;
      del_ok   = 1'b0;
      ins_ok   = 1'b0;
      ins_pos  = '0;
      rd_value = '0;
      status   = ST_DONE;
      case (cmd)
         CMD_READ: begin
            if (pos_ext < occ_ext) begin
               rd_value = cell_value[pos_ext[IDX_W-1:0]];
            end else begin
               rd_value = '1;
               status   = ST_RANGE;
            end
         end
         CMD_INS_HEAD: begin
            ins_req = 1'b1;
            ins_pos = '0;
         end
         CMD_INS_TAIL: begin
            ins_req = 1'b1;
            ins_pos = occ_ext;
         end
         CMD_INS_BEFORE: begin
            ins_req = 1'b1;
            ins_pos = pos_ext;
         end
         CMD_DELETE: begin
            if (pos_ext < occ_ext) begin
               del_ok = 1'b1;
            end else begin
               rd_value = '1;
               status   = ST_RANGE;
            end
         end
         default: begin
            // Unused codes: leave the list alone, report done.
         end
      endcase
      // Range check wins over the full check.
      if (ins_req) begin
         if (ins_pos > occ_ext) begin
            status = ST_RANGE;
         end else if (occ_ext == CMP_W'(CAPACITY)) begin
            status = ST_FULL;
         end else begin
            ins_ok = 1'b1;
         end
      end
   end

   // Broadcast the shift to the cells only for an accepted request.
   always_comb begin
      op.ins = accept & ins_ok;
      op.del = accept & del_ok;
      op.pos = ins_ok ? ins_pos[IDX_W-1:0] : pos_ext[IDX_W-1:0];
   end

   // Advance the count on a completed insert or delete.
   always_comb begin
      occ_in = occ_ff;
      if (op.ins) begin
         occ_in = occ_ff + CNT_W'(1);
      end else if (op.del) begin
         occ_in = occ_ff - CNT_W'(1);
      end
   end

   assign occ_next_ext = CMP_W'(occ_in);

   // Response valid: load on accept, drop once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_read_value_ff <= rd_value;
         rsp_status_ff     <= status;
         rsp_count_ff      <= occ_next_ext[COUNT_W-1:0];
      end
   end

   // Row of cells: on insert those past the position take their left neighbor, on delete those from it their right.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      value_type left_value;
      value_type right_value;
      if (i == 0) begin : g_first
         assign left_value = req_value;
      end else begin : g_left
         assign left_value = cell_value[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_value = cell_value[i];
      end else begin : g_right
         assign right_value = cell_value[i+1];
      end
      ilid_cell u_cell (
         .clock       (clock),
         .op          (op),
         .index       (IDX_W'(i)),
         .left_value  (left_value),
         .right_value (right_value),
         .new_value   (req_value),
         .value       (cell_value[i])
      );
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;

`ifndef SYNTHESIS
   a_occ_bound : assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(CAPACITY))
      else $error("list length beyond capacity");

   a_ins_grows : assert property (@(posedge clock) disable iff (reset)
      (accept && ins_ok) |=> (occ_ff == $past(occ_ff) + CNT_W'(1)))
      else $error("completed insert did not grow the list");

   a_full_status : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_FULL) |-> (occ_ff == CNT_W'(CAPACITY)))
      else $error("full status reported with room left");

   a_count_match : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_count_ff == occ_ext[COUNT_W-1:0]))
      else $error("response count differs from list length");
`endif

endmodule
